### rtl/lgu_pkg.sv
// ----------------------------------------------------------------------------
// lgu_pkg
// Types, constants and helpers shared by the loss and gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lgu_pkg;

    // input data width and the widened width used for saturation
    localparam int DATA_WIDTH    = 32;
    localparam int EXT_W         = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    // default accumulator width and result value width
    localparam int ACC_WIDTH_DEF = 48;
    localparam int VAL_W         = 48;
    // configuration port
    localparam int CFG_W         = 17;
    localparam int CFG_IDX_W     = 3;
    // Q16.16 constants
    localparam int Q_ONE         = 65536;
    localparam int LN2_Q         = 45426;

    // ln(1 + k/16) in Q16.16, k = 0..16
    localparam logic [15:0] LN_TAB [17] = '{
        16'd0,     16'd3973,  16'd7719,  16'd11262, 16'd14624, 16'd17821,
        16'd20870, 16'd23783, 16'd26573, 16'd29248, 16'd31818, 16'd34292,
        16'd36675, 16'd38975, 16'd41196, 16'd43346, 16'd45426
    };

    typedef enum logic [1:0] {
        KIND_SQ   = 2'd0,
        KIND_CE   = 2'd1,
        KIND_KL   = 2'd2,
        KIND_NONE = 2'd3
    } t_loss_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOSS_KIND = 3'd0,
        CFG_GRAD_MODE = 3'd1,
        CFG_FUSED     = 3'd2,
        CFG_INV_BATCH = 3'd3,
        CFG_EPSILON   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] predicted;
        logic signed [DATA_WIDTH-1:0] target_value;
        logic                         last;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    is_total;
        logic                    end_of_run;
    } t_out_item;

    // sign-extend an input word and saturate it to the signed 32 bit range
    function automatic logic signed [31:0] sat_data(input logic [DATA_WIDTH-1:0] v);
        logic signed [EXT_W-1:0] e;
        logic [EXT_W-32:0]       top;
        e   = EXT_W'($signed(v));
        top = e[EXT_W-1:31];
        if ((&top) || !(|top)) begin
            return e[31:0];
        end else if (e[EXT_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7FFF_FFFF;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/loss_and_gradient_unit.sv
// ----------------------------------------------------------------------------
// loss_and_gradient_unit
// Per-element squared error, cross-entropy and KL loss or gradient in Q16.16,
// computed on one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_stall o_out_item (t_out_item)
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
//  one item at a time; o_in_stall is high from acceptance until the result
//  sits in the output register, or until a non-final loss item is summed.
//  log evaluations use the 5-step normalizer and the shared multiplier;
//  the unfused cross-entropy gradient uses the one-bit-per-cycle divider.
//  reset is synchronous; it clears the sequencer, registers and loss sum.
//  a stalled output holds the finished item; the next item is accepted and
//  computed, then waits in the done state until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module loss_and_gradient_unit
    import lgu_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire t_in_item             i_in_item,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output t_out_item                 o_out_item,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SUM_W     = ((ACC_WIDTH > 50) ? ACC_WIDTH : 50) + 1;
    localparam int OUT_EW    = (ACC_WIDTH > VAL_W) ? ACC_WIDTH : VAL_W;
    localparam int DIV_STEPS = 48;
    localparam int NORM_LAST = 4;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef enum logic [20:0] {
        S_IDLE      = 21'h000001,
        S_START     = 21'h000002,
        S_SQ        = 21'h000004,
        S_SQ_END    = 21'h000008,
        S_LN_ARG    = 21'h000010,
        S_LN_NORM   = 21'h000020,
        S_LN_INTERP = 21'h000040,
        S_LN_EXP    = 21'h000080,
        S_LN_SUM    = 21'h000100,
        S_CE_MUL    = 21'h000200,
        S_CE_ACC    = 21'h000400,
        S_DEN_MUL   = 21'h000800,
        S_DEN       = 21'h001000,
        S_DIV_INIT  = 21'h002000,
        S_DIV       = 21'h004000,
        S_DIV_END   = 21'h008000,
        S_SCL_HI    = 21'h010000,
        S_SCL_LO    = 21'h020000,
        S_SCL_END   = 21'h040000,
        S_ACC       = 21'h080000,
        S_DONE      = 21'h100000
    } t_state;

    t_state                   r_state;
    t_loss_kind               r_kind;
    logic                     r_gmode;
    logic                     r_fused;
    logic [16:0]              r_scale;
    logic [15:0]              r_eps;
    logic signed [31:0]       r_o;
    logic signed [31:0]       r_t;
    logic                     r_last;
    logic [1:0]               r_pass;
    logic [5:0]               r_cnt;
    logic [31:0]              r_x;
    logic [4:0]               r_sh;
    logic signed [17:0]       r_lnacc;
    logic signed [23:0]       r_ln;
    logic signed [67:0]       r_prod;
    logic signed [49:0]       r_v;
    logic signed [VAL_W-1:0]  r_g;
    logic signed [48:0]       r_den;
    logic [47:0]              r_dd;
    logic [47:0]              r_dq;
    logic [48:0]              r_rem;
    logic                     r_neg;
    logic [49:0]              r_hi;
    logic signed [VAL_W-1:0]  r_res_value;
    logic                     r_res_total;
    logic                     r_res_eor;
    logic signed [ACC_WIDTH-1:0] r_loss_sum;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic signed [ACC_WIDTH-1:0] n_loss_sum;

    // difference of prediction and target and its magnitude
    logic signed [32:0] w_num;
    logic signed [32:0] w_num_neg;
    logic [31:0]        w_ad;
    assign w_num     = 33'(r_o) - 33'(r_t);
    assign w_num_neg = -w_num;
    assign w_ad      = w_num[32] ? w_num_neg[31:0] : w_num[31:0];

    // log argument and coefficient for the current pass
    logic signed [33:0] w_eps_s;
    logic signed [33:0] w_src;
    logic signed [33:0] w_arg;
    logic [31:0]        w_arg_cl;
    logic signed [32:0] w_coef;
    assign w_eps_s  = signed'({18'd0, r_eps});
    assign w_src    = r_pass[1] ? 34'(r_t) : 34'(r_o);
    assign w_arg    = r_pass[0] ? (w_eps_s + 34'sd65536 - w_src) : (w_eps_s + w_src);
    assign w_arg_cl = (w_arg < 34'sd1) ? 32'd1 : w_arg[31:0];
    assign w_coef   = r_pass[0] ? (33'sd65536 - 33'(r_t)) : 33'(r_t);

    // binary search normalizer step
    logic        w_nz;
    logic [31:0] w_nx;
    logic [4:0]  w_amt;
    always_comb begin
        case (r_cnt[2:0])
            3'd0: begin
                w_nz = ~|r_x[31:16]; w_nx = {r_x[15:0], 16'd0}; w_amt = 5'd16;
            end
            3'd1: begin
                w_nz = ~|r_x[31:24]; w_nx = {r_x[23:0], 8'd0};  w_amt = 5'd8;
            end
            3'd2: begin
                w_nz = ~|r_x[31:28]; w_nx = {r_x[27:0], 4'd0};  w_amt = 5'd4;
            end
            3'd3: begin
                w_nz = ~|r_x[31:30]; w_nx = {r_x[29:0], 2'd0};  w_amt = 5'd2;
            end
            default: begin
                w_nz = ~r_x[31];     w_nx = {r_x[30:0], 1'b0};  w_amt = 5'd1;
            end
        endcase
    end

    // table lookup on the mantissa
    logic [3:0]         w_k;
    logic [11:0]        w_r;
    logic [15:0]        w_tab_lo;
    logic [15:0]        w_tab_hi;
    logic [15:0]        w_tdiff;
    logic signed [5:0]  w_exp;
    assign w_k      = r_x[30:27];
    assign w_r      = r_x[26:15];
    assign w_tab_lo = LN_TAB[{1'b0, w_k}];
    assign w_tab_hi = LN_TAB[5'({1'b0, w_k}) + 5'd1];
    assign w_tdiff  = w_tab_hi - w_tab_lo;
    assign w_exp    = 6'sd15 - signed'({1'b0, r_sh});

    // gradient magnitude
    logic signed [VAL_W-1:0] w_g_neg;
    logic [VAL_W-1:0]        w_ag;
    assign w_g_neg = -r_g;
    assign w_ag    = r_g[VAL_W-1] ? w_g_neg : r_g;

    // shared multiplier operand select
    logic signed [33:0] w_ma;
    logic signed [33:0] w_mb;
    always_comb begin
        case (r_state)
            S_SQ: begin
                w_ma = {2'b00, w_ad};
                w_mb = {2'b00, w_ad};
            end
            S_LN_INTERP: begin
                w_ma = {18'd0, w_tdiff};
                w_mb = {22'd0, w_r};
            end
            S_LN_EXP: begin
                w_ma = 34'(w_exp);
                w_mb = 34'(LN2_Q);
            end
            S_CE_MUL: begin
                w_ma = 34'(w_coef);
                w_mb = 34'(r_ln);
            end
            S_DEN_MUL: begin
                w_ma = 34'(r_o);
                w_mb = 34'sd65536 - 34'(r_o);
            end
            S_SCL_HI: begin
                w_ma = {2'b00, w_ag[47:16]};
                w_mb = {17'd0, r_scale};
            end
            S_SCL_LO: begin
                w_ma = {18'd0, w_ag[15:0]};
                w_mb = {17'd0, r_scale};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // log term, floor of product over one
    logic signed [39:0] w_term;
    assign w_term = r_prod[55:16];

    // divider step
    logic signed [48:0] w_den_neg;
    logic [48:0]        w_trial;
    logic [49:0]        w_sub;
    logic               w_ge;
    assign w_den_neg = -r_den;
    assign w_trial   = {r_rem[47:0], r_dq[47]};
    assign w_sub     = {1'b0, w_trial} - {2'b00, r_dd};
    assign w_ge      = ~w_sub[49];

    // quotient saturation and sign
    logic [47:0]             w_qs;
    logic signed [VAL_W-1:0] w_qs_neg;
    assign w_qs     = r_dq[47] ? VAL_MAX : r_dq;
    assign w_qs_neg = -signed'(w_qs);

    // scaled gradient sum and saturation
    logic [50:0]             w_ssum;
    logic [VAL_W-1:0]        w_smag;
    logic signed [VAL_W-1:0] w_smag_neg;
    assign w_ssum     = 51'(r_hi) + 51'(r_prod[33:16]);
    assign w_smag     = (w_ssum > 51'(VAL_MAX)) ? VAL_MAX : w_ssum[VAL_W-1:0];
    assign w_smag_neg = -signed'(w_smag);

    // saturating accumulate
    logic signed [SUM_W-1:0]       w_sum;
    logic [SUM_W-ACC_WIDTH:0]      w_sum_top;
    assign w_sum     = SUM_W'(r_loss_sum) + SUM_W'(r_v);
    assign w_sum_top = w_sum[SUM_W-1:ACC_WIDTH-1];
    always_comb begin
        if ((&w_sum_top) || !(|w_sum_top)) begin
            n_loss_sum = w_sum[ACC_WIDTH-1:0];
        end else if (w_sum[SUM_W-1]) begin
            n_loss_sum = ACC_MIN;
        end else begin
            n_loss_sum = ACC_MAX;
        end
    end

    // total clipped to the value range
    logic signed [OUT_EW-1:0]  w_tot_ext;
    logic [OUT_EW-VAL_W:0]     w_tot_top;
    logic signed [VAL_W-1:0]   w_total;
    assign w_tot_ext = OUT_EW'(n_loss_sum);
    assign w_tot_top = w_tot_ext[OUT_EW-1:VAL_W-1];
    always_comb begin
        if ((&w_tot_top) || !(|w_tot_top)) begin
            w_total = w_tot_ext[VAL_W-1:0];
        end else if (w_tot_ext[OUT_EW-1]) begin
            w_total = VAL_MIN;
        end else begin
            w_total = VAL_MAX;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_SQ;
            r_gmode <= 1'b0;
            r_fused <= 1'b0;
            r_scale <= 17'd65536;
            r_eps   <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOSS_KIND: r_kind  <= t_loss_kind'(i_cfg_data[1:0]);
                CFG_GRAD_MODE: r_gmode <= i_cfg_data[0];
                CFG_FUSED:     r_fused <= i_cfg_data[0];
                CFG_INV_BATCH: r_scale <= i_cfg_data[16:0];
                CFG_EPSILON:   r_eps   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_loss_sum <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_o     <= sat_data(i_in_item.predicted);
                        r_t     <= sat_data(i_in_item.target_value);
                        r_last  <= i_in_item.last;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_pass <= 2'd0;
                    r_v    <= '0;
                    if (r_gmode) begin
                        if (r_kind == KIND_NONE) begin
                            r_g     <= '0;
                            r_state <= S_SCL_HI;
                        end else if (r_kind == KIND_SQ || r_fused) begin
                            r_g     <= VAL_W'(w_num);
                            r_state <= S_SCL_HI;
                        end else if (w_num == 33'sd0) begin
                            r_g     <= '0;
                            r_state <= S_SCL_HI;
                        end else begin
                            r_state <= S_DEN_MUL;
                        end
                    end else begin
                        case (r_kind)
                            KIND_SQ:          r_state <= S_SQ;
                            KIND_CE, KIND_KL: r_state <= S_LN_ARG;
                            default:          r_state <= S_ACC;
                        endcase
                    end
                end
                // squared error loss
                S_SQ: r_state <= S_SQ_END;
                S_SQ_END: begin
                    r_v     <= signed'({1'b0, r_prod[65:17]});
                    r_state <= S_ACC;
                end
                // natural log of one argument
                S_LN_ARG: begin
                    r_x     <= w_arg_cl;
                    r_sh    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_LN_NORM;
                end
                S_LN_NORM: begin
                    if (w_nz) begin
                        r_x  <= w_nx;
                        r_sh <= r_sh + w_amt;
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(NORM_LAST)) begin
                        r_state <= S_LN_INTERP;
                    end
                end
                S_LN_INTERP: r_state <= S_LN_EXP;
                S_LN_EXP: begin
                    r_lnacc <= signed'({2'b00, w_tab_lo}) + signed'({6'd0, r_prod[23:12]});
                    r_state <= S_LN_SUM;
                end
                S_LN_SUM: begin
                    r_ln    <= 24'(r_lnacc) + signed'(r_prod[23:0]);
                    r_state <= S_CE_MUL;
                end
                S_CE_MUL: r_state <= S_CE_ACC;
                S_CE_ACC: begin
                    // first two passes subtract, the target self-entropy passes add
                    r_v    <= r_pass[1] ? (r_v + 50'(w_term)) : (r_v - 50'(w_term));
                    r_pass <= r_pass + 2'd1;
                    if ((r_kind == KIND_CE && r_pass == 2'd1) || r_pass == 2'd3) begin
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_LN_ARG;
                    end
                end
                // cross-entropy gradient divisor
                S_DEN_MUL: r_state <= S_DEN;
                S_DEN: begin
                    r_den   <= 49'(w_eps_s) + signed'(r_prod[64:16]);
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    if (r_den == 49'sd0) begin
                        r_g     <= w_num[32] ? VAL_MIN : VAL_MAX;
                        r_state <= S_SCL_HI;
                    end else begin
                        r_dd    <= r_den[48] ? w_den_neg[47:0] : r_den[47:0];
                        r_dq    <= {w_ad, 16'd0};
                        r_rem   <= '0;
                        r_neg   <= w_num[32] ^ r_den[48];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                // restoring division, one quotient bit per cycle
                S_DIV: begin
                    r_rem <= w_ge ? w_sub[48:0] : w_trial;
                    r_dq  <= {r_dq[46:0], w_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_g     <= r_neg ? w_qs_neg : signed'(w_qs);
                    r_state <= S_SCL_HI;
                end
                // gradient times inverse batch size
                S_SCL_HI: r_state <= S_SCL_LO;
                S_SCL_LO: begin
                    r_hi    <= r_prod[49:0];
                    r_state <= S_SCL_END;
                end
                S_SCL_END: begin
                    r_res_value <= r_g[VAL_W-1] ? w_smag_neg : signed'(w_smag);
                    r_res_total <= 1'b0;
                    r_res_eor   <= r_last;
                    r_state     <= S_DONE;
                end
                // loss accumulation and total on the last item
                S_ACC: begin
                    if (r_last) begin
                        r_loss_sum  <= '0;
                        r_res_value <= (r_kind == KIND_NONE) ? '0 : w_total;
                        r_res_total <= 1'b1;
                        r_res_eor   <= 1'b1;
                        r_state     <= S_DONE;
                    end else begin
                        r_loss_sum <= n_loss_sum;
                        r_state    <= S_IDLE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out.value      <= r_res_value;
            r_out.is_total   <= r_res_total;
            r_out.end_of_run <= r_res_eor;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // an accepted item always starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_START))
        else $error("accepted item did not start the sequencer");

    // the divider never runs past its last quotient bit
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < 6'(DIV_STEPS)))
        else $error("divider step count out of range");

    // a loss total is always the end of a run
    a_total_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.is_total || o_out_item.end_of_run))
        else $error("loss total without end of run");

    // gradient items leave the loss sum alone
    a_grad_keeps_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCL_END) |=> $stable(r_loss_sum))
        else $error("loss sum changed by a gradient item");

endmodule

`default_nettype wire
